/* hdl/utf8r_pkg.sv */
// Package for the UTF-8 byte repair block: result lane and held-sequence types and constants.
// Has no dependencies; it is used by utf8r_decode, the top level and the testbench.
package utf8r_pkg;

    // Replacement character for any byte outside a well-formed sequence.
    localparam logic [7:0] QMARK = 8'h3F;

    // One byte can release at most four results: three held bytes and itself.
    localparam int MAX_RESULTS = 4;
    localparam int LANE_W      = 2;
    localparam int RES_CNT_W   = 3;
    localparam int HELD_DEPTH  = 3;

    // Byte classes of the UTF-8 rules.
    localparam logic [7:0] ASCII_TOP   = 8'h7F;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] E0_CONT_LO  = 8'hA0;
    localparam logic [7:0] ED_CONT_HI  = 8'h9F;
    localparam logic [7:0] F0_CONT_LO  = 8'h90;
    localparam logic [7:0] F4_CONT_HI  = 8'h8F;

    // Expected sequence lengths.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // One result byte as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       last;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_lanes_t;

    // The open sequence: held bytes, how many are held, and its expected length.
    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] held;
        logic [1:0]                 held_count;
        logic [2:0]                 seq_len;
    } seq_state_t;

endpackage

/* hdl/utf8r_if.sv */
// Request channels of the UTF-8 byte repair block: raw bytes in, repaired bytes out.
// Has no dependencies.
interface utf8r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       out_last;

    modport source (output valid, output out_byte, output was_replaced, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input was_replaced, input out_last,
                    output ready);
endinterface

/* hdl/utf8r_decode.sv */
// Next-state and result logic for one byte of the UTF-8 repair block.
// Depends on utf8r_pkg.
module utf8r_decode (
    input  logic [7:0]              data,
    input  logic                    last,
    input  utf8r_pkg::seq_state_t   st,
    output utf8r_pkg::seq_state_t   st_next,
    output utf8r_pkg::result_lanes_t lanes,
    output logic [2:0]              n_results
);
    import utf8r_pkg::*;

    logic [7:0]           lo;
    logic [7:0]           hi;
    logic                 taken;
    logic [2:0]           len;
    logic [RES_CNT_W-1:0] n;
    seq_state_t           nx;

    always_comb
    begin
        lanes = '0;
        n     = '0;
        nx    = st;
        taken = 1'b0;
        lo    = CONT_LO;
        hi    = CONT_HI;
        len   = SEQ_NONE;

        // An open sequence: check the byte as its next continuation.
        if (st.seq_len != SEQ_NONE && st.held_count != 2'd0)
        begin
            if (st.held_count == 2'd1)
            begin
                if (st.held[0] == LEAD_E0)
                    lo = E0_CONT_LO;
                else if (st.held[0] == LEAD_ED)
                    hi = ED_CONT_HI;
                else if (st.held[0] == LEAD_F0)
                    lo = F0_CONT_LO;
                else if (st.held[0] == LEAD_F4)
                    hi = F4_CONT_HI;
            end
            if (data >= lo && data <= hi)
            begin
                taken = 1'b1;
                if ({1'b0, st.held_count} + 3'd1 >= st.seq_len)
                begin
                    // Sequence complete: release it unchanged.
                    for (int i = 0; i < HELD_DEPTH; i++)
                    begin
                        if (2'(i) < st.held_count)
                        begin
                            lanes[n[LANE_W-1:0]] = '{data: st.held[i], repl: 1'b0, last: 1'b0};
                            n = n + 3'd1;
                        end
                    end
                    lanes[n[LANE_W-1:0]] = '{data: data, repl: 1'b0, last: 1'b0};
                    n = n + 3'd1;
                    nx.held_count = 2'd0;
                    nx.seq_len    = SEQ_NONE;
                end
                else if (st.held_count < 2'd3)
                begin
                    nx.held[st.held_count] = data;
                    nx.held_count          = st.held_count + 2'd1;
                end
            end
            else
            begin
                // Broken sequence: every held byte is replaced.
                for (int i = 0; i < HELD_DEPTH; i++)
                begin
                    if (2'(i) < st.held_count)
                    begin
                        lanes[n[LANE_W-1:0]] = '{data: QMARK, repl: 1'b1, last: 1'b0};
                        n = n + 3'd1;
                    end
                end
                nx.held_count = 2'd0;
                nx.seq_len    = SEQ_NONE;
            end
        end
        else
        begin
            nx.held_count = 2'd0;
            nx.seq_len    = SEQ_NONE;
        end

        // Judge the byte as a start byte when no sequence took it.
        if (!taken)
        begin
            if (data <= ASCII_TOP)
            begin
                lanes[n[LANE_W-1:0]] = '{data: data, repl: 1'b0, last: 1'b0};
                n = n + 3'd1;
            end
            else if (data >= LEAD2_LO && data <= LEAD2_HI)
                len = SEQ_TWO;
            else if (data >= LEAD3_LO && data <= LEAD3_HI)
                len = SEQ_THREE;
            else if (data >= LEAD4_LO && data <= LEAD4_HI)
                len = SEQ_FOUR;
            else
            begin
                lanes[n[LANE_W-1:0]] = '{data: QMARK, repl: 1'b1, last: 1'b0};
                n = n + 3'd1;
            end
            if (len != SEQ_NONE)
            begin
                nx.held[0]    = data;
                nx.held_count = 2'd1;
                nx.seq_len    = len;
            end
        end

        // End of text: whatever is still held is replaced, and the last result is marked.
        if (last)
        begin
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (2'(i) < nx.held_count)
                begin
                    lanes[n[LANE_W-1:0]] = '{data: QMARK, repl: 1'b1, last: 1'b0};
                    n = n + 3'd1;
                end
            end
            nx.held_count = 2'd0;
            nx.seq_len    = SEQ_NONE;
            if (n != 3'd0)
                lanes[LANE_W'(n - 3'd1)].last = 1'b1;
        end
    end

    assign st_next   = nx;
    assign n_results = n;

endmodule

/* hdl/utf8_invalid_byte_replacer_unit.sv */
// Top level of the UTF-8 byte repair block: input stage, sequence state and result queue.
// Depends on utf8r_pkg, utf8r_if and utf8r_decode.
//
//  channel  | dir | payload                            | request taken when
//  ---------+-----+------------------------------------+--------------------
//  in_ch    | in  | in_byte[7:0], in_last              | valid && ready
//  out_ch   | out | out_byte[7:0], was_replaced,       | valid && ready
//           |     | out_last                           |
//
// One byte is taken per cycle while the input stage can move on; it is registered in the
// input stage, judged there, and its results are registered in the result queue. A byte
// that ends a sequence releases up to four results at once; they drain one a cycle while
// the output is ready, and the input stage holds while the queue has fewer than four free
// entries. Reset clears the open sequence and empties both stages. A stalled output blocks
// the input only once the queue holds more than OUTQ_DEPTH - 4 results.
module utf8_invalid_byte_replacer_unit #(
    parameter int OUTQ_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    utf8r_in_if.sink           in_ch,
    utf8r_out_if.source        out_ch
);
    import utf8r_pkg::*;

    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Input stage.
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_last_reg;
    logic       in_take;
    logic       go;

    // Open sequence.
    logic [HELD_DEPTH-1:0][7:0] held_reg;
    logic [1:0]                 held_count_reg;
    logic [2:0]                 seq_len_reg;
    seq_state_t                 st;
    seq_state_t                 st_next;
    result_lanes_t              lanes;
    logic [2:0]                 n_results;

    // Result queue; slot 0 is the head.
    result_t    q_reg  [OUTQ_DEPTH];
    result_t    q_next [OUTQ_DEPTH];
    result_t    q_shift [OUTQ_DEPTH];
    logic [CNT_W-1:0] q_count_reg;
    logic [CNT_W-1:0] q_count_next;
    logic [CNT_W-1:0] q_base;
    logic [CNT_W-1:0] q_off;
    logic [CNT_W-1:0] push_n;
    logic             pop;

    // The stage moves on when the queue can take a full group of results.
    assign go      = stg_valid_reg && (q_count_reg <= CNT_W'(OUTQ_DEPTH - MAX_RESULTS));
    assign in_ch.ready = !stg_valid_reg || go;
    assign in_take = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_ch.ready)
            stg_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stg_byte_reg <= in_ch.in_byte;
            stg_last_reg <= in_ch.in_last;
        end
    end

    // Judge the staged byte against the open sequence.
    assign st.held       = held_reg;
    assign st.held_count = held_count_reg;
    assign st.seq_len    = seq_len_reg;

    utf8r_decode u_decode (
        .data      (stg_byte_reg),
        .last      (stg_last_reg),
        .st        (st),
        .st_next   (st_next),
        .lanes     (lanes),
        .n_results (n_results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= SEQ_NONE;
        end
        else if (go)
        begin
            held_count_reg <= st_next.held_count;
            seq_len_reg    <= st_next.seq_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            held_reg <= st_next.held;
    end

    // Queue update: drop the head on a pop, append the new results behind what remains.
    assign pop    = (q_count_reg != '0) && out_ch.ready;
    assign push_n = go ? CNT_W'(n_results) : '0;
    assign q_base = q_count_reg - CNT_W'(pop);
    assign q_count_next = q_base + push_n;

    always_comb
    begin
        for (int i = 0; i < OUTQ_DEPTH - 1; i++)
            q_shift[i] = q_reg[i + 1];
        q_shift[OUTQ_DEPTH-1] = q_reg[OUTQ_DEPTH-1];
    end

    always_comb
    begin
        q_off = '0;
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            q_off     = CNT_W'(i) - q_base;
            if (CNT_W'(i) < q_base)
                q_next[i] = pop ? q_shift[i] : q_reg[i];
            else if (q_off < push_n)
                q_next[i] = lanes[q_off[LANE_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_count_reg <= '0;
        else
            q_count_reg <= q_count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUTQ_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    // Head of the queue drives the output channel.
    assign out_ch.valid        = (q_count_reg != '0);
    assign out_ch.out_byte     = q_reg[0].data;
    assign out_ch.was_replaced = q_reg[0].repl;
    assign out_ch.out_last     = q_reg[0].last;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the UTF-8 byte repair block: directed and random byte texts,
// each result compared with a behavioural prediction of the repair.
// Depends on utf8r_pkg, utf8r_in_if, utf8r_out_if and utf8_invalid_byte_replacer_unit.
module tb_top;

    import utf8r_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX    = 10;

    logic clk;
    logic rst_n;

    utf8r_in_if  in_ch ();
    utf8r_out_if out_ch ();

    utf8_invalid_byte_replacer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Idling odds in percent per cycle, and a hold-off on the result side.
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    // Predicted state of the open sequence.
    logic [7:0] open_held [HELD_DEPTH];
    logic [1:0] open_count;
    logic [2:0] open_len;

    // Results of the byte being predicted, and the queue of bytes still to come out.
    result_t step_res [MAX_RESULTS];
    int      step_n;
    result_t expected_bytes [$];

    int mismatch_count;
    int stall_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Append one predicted result byte for the current request.
    function automatic void note_byte(input logic [7:0] b, input logic repl);
        step_res[step_n].data = repl ? QMARK : b;
        step_res[step_n].repl = repl;
        step_res[step_n].last = 1'b0;
        step_n++;
    endfunction

    // Release every held byte, either unchanged or as question marks, and close the sequence.
    function automatic void release_held(input logic repl);
        int i;
        for (i = 0; i < open_count; i++)
            note_byte(open_held[i], repl);
        open_count = '0;
        open_len   = SEQ_NONE;
    endfunction

    // Work out the result bytes caused by one accepted byte and queue them in order.
    function automatic void predict_repair(input logic [7:0] b, input logic end_text);
        logic [7:0] lo;
        logic [7:0] hi;
        logic       taken;
        int         i;
        step_n = 0;
        taken  = 1'b0;
        if (open_len != SEQ_NONE && open_count != 0)
        begin
            lo = CONT_LO;
            hi = CONT_HI;
            // Only the byte straight after the lead has a narrowed range.
            if (open_count == 1)
            begin
                if (open_held[0] == LEAD_E0)
                    lo = E0_CONT_LO;
                else if (open_held[0] == LEAD_ED)
                    hi = ED_CONT_HI;
                else if (open_held[0] == LEAD_F0)
                    lo = F0_CONT_LO;
                else if (open_held[0] == LEAD_F4)
                    hi = F4_CONT_HI;
            end
            if (b >= lo && b <= hi)
            begin
                taken = 1'b1;
                if (open_count + 1 >= open_len)
                begin
                    release_held(1'b0);
                    note_byte(b, 1'b0);
                end
                else
                begin
                    open_held[open_count] = b;
                    open_count = open_count + 2'd1;
                end
            end
            else
            begin
                release_held(1'b1);
            end
        end
        else
        begin
            open_count = '0;
            open_len   = SEQ_NONE;
        end
        // A byte that did not continue the sequence is judged as a fresh start.
        if (!taken)
        begin
            if (b <= ASCII_TOP)
                note_byte(b, 1'b0);
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
                open_len = SEQ_TWO;
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
                open_len = SEQ_THREE;
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
                open_len = SEQ_FOUR;
            else
                note_byte(b, 1'b1);
            if (open_len != SEQ_NONE)
            begin
                open_held[0] = b;
                open_count   = 2'd1;
            end
        end
        // End of text: anything still held is spoilt, and the final result carries the mark.
        if (end_text)
        begin
            release_held(1'b1);
            if (step_n > 0)
                step_res[step_n-1].last = 1'b1;
        end
        for (i = 0; i < step_n; i++)
            expected_bytes.push_back(step_res[i]);
    endfunction

    // Every accepted request on the input is fed to the prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_repair(in_ch.in_byte, in_ch.in_last);
    end

    // Each result that leaves the block is compared with the oldest expected byte.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: byte %02h replaced %0b last %0b",
                             out_ch.out_byte, out_ch.was_replaced, out_ch.out_last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_ch.out_byte !== want.data || out_ch.was_replaced !== want.repl ||
                    out_ch.out_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 want.data, want.repl, want.last, out_ch.out_byte,
                                 out_ch.was_replaced, out_ch.out_last);
                end
            end
        end
    end

    // Result-side readiness: a counted hold-off first, otherwise random idling.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: ends the run when no request moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one byte, idling at random beforehand, and return once it has been taken.
    task automatic send_byte(input logic [7:0] b, input logic end_text);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= end_text;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // A random well-formed character of one to four bytes.
    function automatic void random_char(output logic [3:0][7:0] c, output int n);
        int i;
        c = '0;
        n = $urandom_range(4, 1);
        for (i = 1; i < 4; i++)
            c[i] = 8'($urandom_range(CONT_HI, CONT_LO));
        case (n)
            1: c[0] = 8'($urandom_range(ASCII_TOP, 0));
            2: c[0] = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            3:
            begin
                c[0] = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
                if (c[0] == LEAD_E0)
                    c[1] = 8'($urandom_range(CONT_HI, E0_CONT_LO));
                else if (c[0] == LEAD_ED)
                    c[1] = 8'($urandom_range(ED_CONT_HI, CONT_LO));
            end
            default:
            begin
                c[0] = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
                if (c[0] == LEAD_F0)
                    c[1] = 8'($urandom_range(CONT_HI, F0_CONT_LO));
                else if (c[0] == LEAD_F4)
                    c[1] = 8'($urandom_range(F4_CONT_HI, CONT_LO));
            end
        endcase
    endfunction

    // Random text: mostly whole characters, some cut short, some arbitrary bytes.
    task automatic send_random_text(input int count);
        logic [3:0][7:0] c;
        int              n;
        int              keep;
        int              pick;
        int              sent;
        int              i;
        sent = 0;
        while (sent < count)
        begin
            random_char(c, n);
            pick = $urandom_range(99);
            if (pick < 70)
                keep = n;
            else if (pick < 85 && n > 1)
                keep = $urandom_range(n - 1, 1);
            else
            begin
                c[0] = 8'($urandom_range(255, 0));
                keep = 1;
            end
            for (i = 0; i < keep; i++)
            begin
                send_byte(c[i], $urandom_range(24) == 0);
                sent++;
            end
        end
    endtask

    // Lone bytes: ASCII extremes, bad start bytes, and a NUL straight after an invalid run.
    task automatic test_single_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Second bytes at the edges of their permitted ranges, accepted and refused.
    task automatic test_second_byte_limits();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8F, 1'b0);
    endtask

    // A sequence broken after three held bytes, and a text ending inside a sequence.
    task automatic test_broken_and_text_end();
        send_byte(8'hED, 1'b0);
        send_byte(8'h9F, 1'b1);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);
    endtask

    // The result side holds off for a long stretch while bytes keep coming.
    task automatic test_output_hold_off();
        hold_left = 150;
        send_random_text(30);
        send_byte(8'h0A, 1'b1);
    endtask

    // The input side pauses until every result has come out, then carries on.
    task automatic test_pause_for_drain();
        send_random_text(10);
        wait_for_drain();
        send_random_text(10);
        send_byte(8'h0A, 1'b1);
    endtask

    // Random text under one idling pattern.
    task automatic test_random_text(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        send_random_text(count);
        send_byte(8'h0A, 1'b1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.in_last  = 1'b0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 27;
        recv_idle_pct  = 75;
        hold_left      = 0;
        open_count     = '0;
        open_len       = SEQ_NONE;
        mismatch_count = 0;
        stall_cycles   = 0;
        for (int i = 0; i < HELD_DEPTH; i++)
            open_held[i] = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_bytes();
        test_second_byte_limits();
        test_broken_and_text_end();
        test_output_hold_off();
        test_pause_for_drain();
        test_random_text(27, 75, 60);
        test_random_text(75, 27, 70);
        test_random_text(0, 0, 70);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
